// ===== src/acl_entry_set_validator_defines.svh =====
// Assertion macros used by the checker of the ACL entry set validator.
`ifndef ACL_ENTRY_SET_VALIDATOR_DEFINES_SVH
`define ACL_ENTRY_SET_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked on rising clk outside reset.
`define AESV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on rising clk outside reset.
`define AESV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/aesv_pkg.sv =====
// Shared types and constants for the ACL entry set validator.
package aesv_pkg;

  localparam int ID_BITS_DEF = 32;

  localparam int TYPE_W   = 4;
  localparam int ID_W     = 32;
  localparam int PERM_W   = 8;
  localparam int CNT_W    = 2;

  localparam int NUM_TYPES = 12;
  localparam int GROUP_N   = 6;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam logic [PERM_W-1:0] PERM_MAX = 8'd7;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 2'd3;
  localparam logic [CNT_W-1:0]  CNT_ONE  = 2'd1;

  // entry type codes within one group; default group starts at T_DEF
  localparam int T_OWNER  = 0;
  localparam int T_USER   = 1;
  localparam int T_OGROUP = 2;
  localparam int T_GROUP  = 3;
  localparam int T_MASK   = 4;
  localparam int T_OTHER  = 5;
  localparam int T_DEF    = 6;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef cnt_t [GROUP_N-1:0] grp_cnt_t;
  typedef cnt_t [NUM_TYPES-1:0] all_cnt_t;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic [ID_W-1:0]   id;
    logic [PERM_W-1:0] perm;
    logic              last;
  } entry_t;

  // status from the check core to the result register
  typedef struct packed {
    logic done;   // a last entry retires this cycle
    logic ok;     // verdict for that set
  } verdict_t;

endpackage

// ===== src/acl_entry_set_validator.sv =====
// An accepted entry word is captured in the input register and judged while held; on a last
//   entry the verdict word is registered into the result register as that entry retires.
// Throughput: one entry word per cycle; the only stall is a last entry meeting a result
//   word the output side has not yet taken (set by the single result register).
// Reset (rst, synchronous, active high): clears both stage valids and all per-set state.
module acl_entry_set_validator #(
  parameter int ID_BITS = aesv_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // entry words in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] entry_type, [35:4] entry_id, [43:36] entry_perm, [47:44] zero
  input  logic [aesv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,    // last_entry
  // verdict words out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] acl_valid, [7:1] zero
  output logic [aesv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic               held_valid;
  aesv_pkg::entry_t   held;
  logic               advance;
  aesv_pkg::verdict_t verdict;

  // A held entry retires unless it is a last entry and the result slot is
  // still occupied and not being drained this cycle.
  assign advance = held_valid && (!held.last || !m_axis_tvalid || m_axis_tready);

  aesv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  // Counters, sticky error and repeat compare; verdict formed on the count
  // values that include the retiring entry.
  aesv_core #(
    .ID_BITS (ID_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (advance),
    .ent     (held),
    .verdict (verdict)
  );

  aesv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .verdict   (verdict),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== src/aesv_in_stage.sv =====
// Input register stage: captures one entry word per accepted handshake.
module aesv_in_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [aesv_pkg::IN_TDATA_W-1:0]     in_data,
  input  logic                                in_last,
  input  logic                                advance,   // held entry retires
  output logic                                held_valid,
  output aesv_pkg::entry_t                    held
);

  logic fire;

  assign in_ready = !held_valid || advance;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held.etype <= in_data[3:0];
      held.id    <= in_data[35:4];
      held.perm  <= in_data[43:36];
      held.last  <= in_last;
    end
  end

endmodule

// ===== src/aesv_core.sv =====
// Per-set state: type counters, sticky error, previous-entry compare and verdict.
module aesv_core #(
  parameter int ID_BITS = aesv_pkg::ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  aesv_pkg::entry_t   ent,
  output aesv_pkg::verdict_t verdict
);

  localparam int CMP_BITS = (ID_BITS < aesv_pkg::ID_W) ? ID_BITS : aesv_pkg::ID_W;

  aesv_pkg::all_cnt_t  cnt, cnt_next;
  logic                err, err_next;
  logic [aesv_pkg::TYPE_W-1:0] prev_type;
  logic [CMP_BITS-1:0] prev_id;
  logic                have_prev;

  logic                unknown, bad_perm, repeat_hit, any_def;
  logic [CMP_BITS-1:0] cur_id;

  function automatic logic group_ok(input aesv_pkg::grp_cnt_t c);
    logic named;
    named = (c[aesv_pkg::T_USER] != '0) || (c[aesv_pkg::T_GROUP] != '0);
    return (c[aesv_pkg::T_OWNER]  == aesv_pkg::CNT_ONE) &&
           (c[aesv_pkg::T_OGROUP] == aesv_pkg::CNT_ONE) &&
           (c[aesv_pkg::T_OTHER]  == aesv_pkg::CNT_ONE) &&
           (!named || (c[aesv_pkg::T_MASK] == aesv_pkg::CNT_ONE));
  endfunction

  assign cur_id     = ent.id[CMP_BITS-1:0];
  assign unknown    = ent.etype >= aesv_pkg::TYPE_W'(aesv_pkg::NUM_TYPES);
  assign bad_perm   = ent.perm > aesv_pkg::PERM_MAX;
  assign repeat_hit = have_prev && (prev_type == ent.etype) && (prev_id == cur_id);
  assign err_next   = err || unknown || bad_perm || repeat_hit;

  always_comb begin
    for (int i = 0; i < aesv_pkg::NUM_TYPES; i++) begin
      if ((ent.etype == aesv_pkg::TYPE_W'(i)) && (cnt[i] != aesv_pkg::CNT_MAX)) begin
        cnt_next[i] = cnt[i] + aesv_pkg::CNT_W'(1);
      end else begin
        cnt_next[i] = cnt[i];
      end
    end
  end

  assign any_def = cnt_next[aesv_pkg::NUM_TYPES-1:aesv_pkg::T_DEF] != '0;

  assign verdict.done = go && ent.last;
  assign verdict.ok   = !err_next &&
                        group_ok(cnt_next[aesv_pkg::T_DEF-1:0]) &&
                        (!any_def ||
                         group_ok(cnt_next[aesv_pkg::NUM_TYPES-1:aesv_pkg::T_DEF]));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      err       <= 1'b0;
      prev_type <= '0;
      prev_id   <= '0;
      have_prev <= 1'b0;
    end else if (go) begin
      if (ent.last) begin
        cnt       <= '0;
        err       <= 1'b0;
        prev_type <= '0;
        prev_id   <= '0;
        have_prev <= 1'b0;
      end else begin
        cnt       <= cnt_next;
        err       <= err_next;
        prev_type <= ent.etype;
        prev_id   <= cur_id;
        have_prev <= 1'b1;
      end
    end
  end

endmodule

// ===== src/aesv_out_stage.sv =====
// Result register: holds one verdict word until the downstream side takes it.
module aesv_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  aesv_pkg::verdict_t               verdict,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [aesv_pkg::OUT_TDATA_W-1:0] out_data
);

  logic ok_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (verdict.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.done) begin
      ok_q <= verdict.ok;
    end
  end

  assign out_data = {{(aesv_pkg::OUT_TDATA_W-1){1'b0}}, ok_q};

endmodule

// ===== src/aesv_checker.sv =====
// Port-level checker for the ACL entry set validator, bound to the top level.
`include "acl_entry_set_validator_defines.svh"

module aesv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [aesv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [aesv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_last_fire;

  assign in_last_fire = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  `AESV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "verdict word dropped or changed while stalled")

  `AESV_ASSERT_NOW(a_out_cause, $rose(m_axis_tvalid), $past(in_last_fire, 2),
    "verdict word without a last entry two edges earlier")

  `AESV_ASSERT_NOW(a_out_pad, m_axis_tvalid,
    m_axis_tdata[aesv_pkg::OUT_TDATA_W-1:1] == '0, "verdict word padding not zero")

  `AESV_ASSERT_NOW(a_in_open, !m_axis_tvalid, s_axis_tready,
    "input stalled while result slot is empty")

endmodule

bind acl_entry_set_validator aesv_checker u_aesv_checker (.*);

// ===== sim/acl_entry_set_validator_test.sv =====
// Self-checking testbench for the ACL entry set validator: directed table, then random sets.
`timescale 1ns / 100ps

module acl_entry_set_validator_test;

  localparam int RANDOM_WORDS  = 750;
  localparam int CALM_WORDS    = 120;  // last stretch runs with no idling on either side
  localparam int DRAIN_CYCLES  = 4;
  localparam int FROM_PREDICT  = -1;   // directed row whose verdict comes from the predictor
  localparam int BAD_TYPE_MIN  = aesv_pkg::NUM_TYPES;
  localparam int BAD_TYPE_MAX  = 15;

  // ways a well-formed set gets damaged
  typedef enum int {
    MUT_DROP,      // one entry missing
    MUT_REPEAT,    // entry sent twice in a row
    MUT_BAD_PERM,  // permission above the max
    MUT_BAD_TYPE,  // unknown type code
    MUT_RETYPE,    // entry given a random known type, possibly its own
    MUT_EXTRA,     // second entry of a type, other id
    MUT_OVERFLOW   // enough copies to saturate a counter
  } mut_kind_t;

  typedef struct {
    aesv_pkg::entry_t e;
    int               verdict;
  } dir_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [aesv_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic                               s_axis_tlast = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [aesv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

  // predictor state for the set in flight
  aesv_pkg::cnt_t                     set_cnt [aesv_pkg::NUM_TYPES];
  logic                               set_err;
  logic [aesv_pkg::TYPE_W-1:0]        prev_type;
  logic [aesv_pkg::ID_W-1:0]          prev_id;
  logic                               have_prev;

  bit                                 verdict_q [$];   // verdicts still owed by the block
  dir_row_t                           dir_tab [$];
  aesv_pkg::entry_t                   acl_set [$];
  bit                                 idle_on;
  int                                 stall_left;
  int                                 fails;
  int                                 words_sent;
  int                                 sets_sent;
  int                                 n_valid;
  int                                 n_invalid;

  acl_entry_set_validator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [3:0] type, [35:4] id, [43:36] perm, [47:44] zero
    .s_axis_tlast  (s_axis_tlast),   // last entry of the set
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [0] acl_valid, [7:1] zero
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_set();
    foreach (set_cnt[i]) set_cnt[i] = '0;
    set_err   = 1'b0;
    prev_type = '0;
    prev_id   = '0;
    have_prev = 1'b0;
  endfunction

  // owner, owning group and other exactly once; a mask once named entries show up
  function automatic bit group_good(int base);
    return set_cnt[base + aesv_pkg::T_OWNER] == aesv_pkg::CNT_ONE &&
           set_cnt[base + aesv_pkg::T_OGROUP] == aesv_pkg::CNT_ONE &&
           set_cnt[base + aesv_pkg::T_OTHER] == aesv_pkg::CNT_ONE &&
           ((set_cnt[base + aesv_pkg::T_USER] == '0 &&
             set_cnt[base + aesv_pkg::T_GROUP] == '0) ||
            set_cnt[base + aesv_pkg::T_MASK] == aesv_pkg::CNT_ONE);
  endfunction

  // Folds one entry into the set; returns 1 with the verdict when the set closes.
  function automatic bit predict_entry(input aesv_pkg::entry_t e, output bit verdict);
    bit any_def;
    any_def = 1'b0;
    if (e.etype < aesv_pkg::NUM_TYPES) begin
      if (set_cnt[e.etype] != aesv_pkg::CNT_MAX) set_cnt[e.etype]++;
    end else begin
      set_err = 1'b1;
    end
    if (e.perm > aesv_pkg::PERM_MAX) set_err = 1'b1;
    // repeat check covers every type, unknown ones included
    if (have_prev && prev_type == e.etype && prev_id == e.id) set_err = 1'b1;
    prev_type = e.etype;
    prev_id   = e.id;
    have_prev = 1'b1;
    if (!e.last) return 1'b0;
    for (int i = aesv_pkg::T_DEF; i < aesv_pkg::NUM_TYPES; i++)
      if (set_cnt[i] != '0) any_def = 1'b1;
    verdict = !set_err && group_good(0) && (!any_def || group_good(aesv_pkg::T_DEF));
    clear_set();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void dir_row(int t, logic [aesv_pkg::ID_W-1:0] id, int perm,
                                  bit last, int verdict = FROM_PREDICT);
    dir_row_t r;
    r.e.etype = aesv_pkg::TYPE_W'(t);
    r.e.id    = id;
    r.e.perm  = aesv_pkg::PERM_W'(perm);
    r.e.last  = last;
    r.verdict = verdict;
    dir_tab.push_back(r);
  endfunction

  function automatic void push_entry(int t, logic [aesv_pkg::ID_W-1:0] id, int perm);
    aesv_pkg::entry_t e;
    e.etype = aesv_pkg::TYPE_W'(t);
    e.id    = id;
    e.perm  = aesv_pkg::PERM_W'(perm);
    e.last  = 1'b0;
    acl_set.push_back(e);
  endfunction

  // One sorted group of entries: owner, users, owning group, groups, mask, other.
  function automatic void add_group(int base);
    int                        n_named;
    logic [aesv_pkg::ID_W-1:0] nid;
    n_named = 0;
    push_entry(base + aesv_pkg::T_OWNER, $urandom, $urandom_range(0, aesv_pkg::PERM_MAX));
    nid = $urandom >> 1;
    repeat ($urandom_range(0, 3)) begin
      nid += $urandom_range(1, 1000);
      push_entry(base + aesv_pkg::T_USER, nid, $urandom_range(0, aesv_pkg::PERM_MAX));
      n_named++;
    end
    push_entry(base + aesv_pkg::T_OGROUP, $urandom, $urandom_range(0, aesv_pkg::PERM_MAX));
    nid = $urandom >> 1;
    repeat ($urandom_range(0, 3)) begin
      nid += $urandom_range(1, 1000);
      push_entry(base + aesv_pkg::T_GROUP, nid, $urandom_range(0, aesv_pkg::PERM_MAX));
      n_named++;
    end
    // a mask without named entries is legal too
    if (n_named > 0 || $urandom_range(0, 3) == 0)
      push_entry(base + aesv_pkg::T_MASK, $urandom, $urandom_range(0, aesv_pkg::PERM_MAX));
    push_entry(base + aesv_pkg::T_OTHER, $urandom, $urandom_range(0, aesv_pkg::PERM_MAX));
  endfunction

  function automatic void mutate_set();
    int               k;
    aesv_pkg::entry_t x;
    mut_kind_t        m;
    k = $urandom_range(0, acl_set.size() - 1);
    m = mut_kind_t'($urandom_range(MUT_DROP, MUT_OVERFLOW));
    case (m)
      MUT_DROP:     acl_set.delete(k);
      MUT_REPEAT:   acl_set.insert(k, acl_set[k]);
      MUT_BAD_PERM: acl_set[k].perm =
                      aesv_pkg::PERM_W'($urandom_range(aesv_pkg::PERM_MAX + 1, 255));
      MUT_BAD_TYPE: acl_set[k].etype =
                      aesv_pkg::TYPE_W'($urandom_range(BAD_TYPE_MIN, BAD_TYPE_MAX));
      MUT_RETYPE:   acl_set[k].etype =
                      aesv_pkg::TYPE_W'($urandom_range(0, aesv_pkg::NUM_TYPES - 1));
      MUT_EXTRA: begin
        x = acl_set[k];
        x.id = ~x.id;
        acl_set.insert(k, x);
      end
      MUT_OVERFLOW: begin
        x = acl_set[k];
        repeat ($urandom_range(2, 4)) begin
          x.id++;
          acl_set.insert(k, x);
        end
      end
      default: ;
    endcase
  endfunction

  // Short random stream, half the ids from a tiny pool so repeats come up often.
  function automatic void noise_set();
    repeat ($urandom_range(1, 8))
      push_entry($urandom_range(0, BAD_TYPE_MAX),
                 $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, aesv_pkg::PERM_MAX));
  endfunction

  task automatic send_entry(input aesv_pkg::entry_t e, input int typed_verdict);
    bit verdict;
    bit closes;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, e.perm, e.id, e.etype};
    s_axis_tlast  <= e.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    closes = predict_entry(e, verdict);
    if (closes) begin
      verdict_q.push_back(typed_verdict == FROM_PREDICT ? verdict : typed_verdict[0]);
      sets_sent++;
    end
    words_sent++;
  endtask

  // ---------------------------------------------------------------- result side

  // Output stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [aesv_pkg::OUT_TDATA_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict word: expected none, got %0h", $time, m_axis_tdata);
        fails++;
      end else begin
        want = {7'b0, verdict_q.pop_front()};
        if (m_axis_tdata !== want) begin
          $display("%0t: verdict mismatch: expected %0h, got %0h", $time, want, m_axis_tdata);
          fails++;
        end
        if (want[0]) n_valid++;
        else n_invalid++;
      end
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    clear_set();
    idle_on = 1'b1;

    // single unknown entry with all-ones id and perm
    dir_row(BAD_TYPE_MAX, 32'hffff_ffff, 8'hff, 1'b1, 0);
    // smallest legal set
    dir_row(aesv_pkg::T_OWNER, 0, 7, 1'b0);
    dir_row(aesv_pkg::T_OGROUP, 0, 0, 1'b0);
    dir_row(aesv_pkg::T_OTHER, 0, 7, 1'b1, 1);
    // every known type once, access and default
    dir_row(aesv_pkg::T_OWNER, 1000, 6, 1'b0);
    dir_row(aesv_pkg::T_USER, 32'hffff_ffff, 5, 1'b0);
    dir_row(aesv_pkg::T_OGROUP, 1000, 3, 1'b0);
    dir_row(aesv_pkg::T_GROUP, 0, 2, 1'b0);
    dir_row(aesv_pkg::T_MASK, 0, 1, 1'b0);
    dir_row(aesv_pkg::T_OTHER, 0, 0, 1'b0);
    dir_row(aesv_pkg::T_DEF + aesv_pkg::T_OWNER, 1000, 7, 1'b0);
    dir_row(aesv_pkg::T_DEF + aesv_pkg::T_USER, 5, 1, 1'b0);
    dir_row(aesv_pkg::T_DEF + aesv_pkg::T_OGROUP, 7, 2, 1'b0);
    dir_row(aesv_pkg::T_DEF + aesv_pkg::T_GROUP, 8, 3, 1'b0);
    dir_row(aesv_pkg::T_DEF + aesv_pkg::T_MASK, 0, 4, 1'b0);
    dir_row(aesv_pkg::T_DEF + aesv_pkg::T_OTHER, 0, 5, 1'b1, 1);
    // owner sent twice with the same id
    dir_row(aesv_pkg::T_OWNER, 5, 0, 1'b0);
    dir_row(aesv_pkg::T_OWNER, 5, 0, 1'b0);
    dir_row(aesv_pkg::T_OGROUP, 5, 0, 1'b0);
    dir_row(aesv_pkg::T_OTHER, 5, 0, 1'b1, 0);
    // remaining unknown codes, perm just over the max, same id across types
    dir_row(BAD_TYPE_MIN, 1, 8, 1'b0);
    dir_row(13, 1, 0, 1'b0);
    dir_row(14, 1, 0, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_entry(dir_tab[i].e, dir_tab[i].verdict);

    // random sets: mostly built from well-formed groups, half of those damaged, the rest noise
    while (words_sent < dir_tab.size() + RANDOM_WORDS) begin
      idle_on = (words_sent < dir_tab.size() + RANDOM_WORDS - CALM_WORDS) &&
                (sets_sent % 6 != 5);
      acl_set.delete();
      if ($urandom_range(0, 3) != 0) begin
        add_group(0);
        if ($urandom_range(0, 2) == 0) add_group(aesv_pkg::T_DEF);
        if ($urandom_range(0, 1) == 0) mutate_set();
      end else begin
        noise_set();
      end
      acl_set[acl_set.size() - 1].last = 1'b1;
      foreach (acl_set[i]) send_entry(acl_set[i], FROM_PREDICT);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    idle_on = 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d entry words in %0d sets (directed table plus random sets)",
             words_sent, sets_sent);
    $display("verdicts checked: %0d valid, %0d invalid", n_valid, n_invalid);
    if (fails == 0) begin
      $display("acl_entry_set_validator_test: clean");
    end else begin
      $display("acl_entry_set_validator_test: errors");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #400_000;
    $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
    $display("acl_entry_set_validator_test: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/aesv_pkg.sv
src/aesv_in_stage.sv
src/aesv_core.sv
src/aesv_out_stage.sv
src/acl_entry_set_validator.sv
src/aesv_checker.sv
sim/acl_entry_set_validator_test.sv
